// ----- rtl/core/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared widths, codes and types for the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

    // Table size and derived widths
    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int COUNT_W   = 11;
    localparam int SLOT_W    = 10;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 64;
    localparam int LIVE_W    = 11;
    localparam int CAP_W     = 11;
    localparam int STRIDE_W  = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam int PROD_W    = IDX_W + STRIDE_W;
    localparam int SUM_W     = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [LIVE_W-1:0]    live_t;
    typedef logic [CAP_W-1:0]     cap_t;
    typedef logic [STRIDE_W-1:0]  stride_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DAT_W-1:0] cfg_dat_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [SUM_W-1:0]     sum_t;

    // Request commands
    localparam cmd_t CMD_ALLOC_ONE   = 2'd0;
    localparam cmd_t CMD_ALLOC_RANGE = 2'd1;
    localparam cmd_t CMD_FREE        = 2'd2;

    // Response status
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOSPACE = 2'd1;
    localparam status_t ST_BADFREE = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t REG_CAPACITY  = 3'd0;
    localparam cfg_idx_t REG_STRIDE    = 3'd1;
    localparam cfg_idx_t REG_CPU_BASE  = 3'd2;
    localparam cfg_idx_t REG_GPU_BASE  = 3'd3;
    localparam cfg_idx_t REG_SHADER_VIS = 3'd4;

    // Configuration reset values
    localparam cap_t    CAPACITY_RST = cap_t'(1024);
    localparam stride_t STRIDE_RST   = stride_t'(32);

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch request payload
        logic decide;    // update counters, touch the free stack
        logic mul;       // slot index times stride
        logic load_out;  // fill output register
    } ctrl_t;

endpackage

// ----- rtl/core/dsa_req_if.sv -----
// ----------------------------------------------------------------------------
// dsa_req_if
// Request channel: command, range count and slot to free.
// ----------------------------------------------------------------------------
interface dsa_req_if;
    logic          valid;
    logic          ready;
    dsa_pkg::cmd_t   cmd;
    dsa_pkg::count_t count;
    dsa_pkg::slot_t  slot;

    modport source (output valid, output cmd, output count, output slot, input ready);
    modport sink   (input valid, input cmd, input count, input slot, output ready);
endinterface

// ----- rtl/core/dsa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dsa_rsp_if
// Response channel: status, slot, addresses and live count.
// ----------------------------------------------------------------------------
interface dsa_rsp_if;
    logic             valid;
    logic             ready;
    dsa_pkg::status_t status;
    dsa_pkg::slot_t   first_slot;
    dsa_pkg::addr_t   cpu_address;
    dsa_pkg::addr_t   gpu_address;
    dsa_pkg::live_t   live_count;

    modport source (output valid, output status, output first_slot, output cpu_address,
                    output gpu_address, output live_count, input ready);
    modport sink   (input valid, input status, input first_slot, input cpu_address,
                    input gpu_address, input live_count, output ready);
endinterface

// ----- rtl/core/dsa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dsa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dsa_cfg_if;
    logic              valid;
    logic              ready;
    dsa_pkg::cfg_idx_t index;
    dsa_pkg::cfg_dat_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/descriptor_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_unit
// Flow: a request is captured in idle, then decide (counters, stack read),
//   multiply (index times stride), then the 64-bit base add loads the output
//   register once it has drained; no new request is taken before that load.
// A new request is taken while the previous response still waits.
// Reset: mark and stack depth cleared, config to defaults; the free stack
//   memory is not cleared, only entries below the depth are ever read.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_unit (
    input  logic         clk,
    input  logic         rst_n,
    dsa_req_if.sink      req,
    dsa_rsp_if.source    rsp,
    dsa_cfg_if.sink      cfg
);

    dsa_pkg::ctrl_t ctrl;

    // Config writes go straight into the registers, so the channel never stalls.
    assign cfg.ready = 1'b1;

    // Sequencer: idle -> decide -> multiply -> load output.
    dsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    // Datapath: counters, LIFO free stack, address generation, output register.
    dsa_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .req_cmd     (req.cmd),
        .req_count   (req.count),
        .req_slot    (req.slot),
        .status      (rsp.status),
        .first_slot  (rsp.first_slot),
        .cpu_address (rsp.cpu_address),
        .gpu_address (rsp.gpu_address),
        .live_count  (rsp.live_count)
    );

endmodule

// ----- rtl/core/dsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: capture, decide, multiply, load output register.
// ----------------------------------------------------------------------------
module dsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dsa_pkg::ctrl_t ctrl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_MUL    = 2'd2;
    localparam logic [1:0] S_ADD    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctrl.decide = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || rsp_ready)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/dsa_dpath.sv -----
// ----------------------------------------------------------------------------
// dsa_dpath
// Config registers, mark and stack counters, free stack, address math.
// ----------------------------------------------------------------------------
module dsa_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  dsa_pkg::ctrl_t    ctrl,
    // configuration writes
    input  logic              cfg_we,
    input  dsa_pkg::cfg_idx_t cfg_index,
    input  dsa_pkg::cfg_dat_t cfg_data,
    // request payload
    input  dsa_pkg::cmd_t     req_cmd,
    input  dsa_pkg::count_t   req_count,
    input  dsa_pkg::slot_t    req_slot,
    // response payload
    output dsa_pkg::status_t  status,
    output dsa_pkg::slot_t    first_slot,
    output dsa_pkg::addr_t    cpu_address,
    output dsa_pkg::addr_t    gpu_address,
    output dsa_pkg::live_t    live_count
);

    // configuration
    dsa_pkg::cap_t    capacity_reg;
    dsa_pkg::stride_t stride_reg;
    dsa_pkg::addr_t   cpu_base_reg;
    dsa_pkg::addr_t   gpu_base_reg;
    logic             shader_vis_reg;

    // allocator state
    dsa_pkg::cnt_t    high_water_reg;
    dsa_pkg::cnt_t    high_water_next;
    dsa_pkg::cnt_t    free_depth_reg;
    dsa_pkg::cnt_t    free_depth_next;

    // free stack
    dsa_pkg::idx_t    stack_mem [dsa_pkg::MAX_SLOTS];
    dsa_pkg::idx_t    rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    dsa_pkg::idx_t    mem_waddr;
    dsa_pkg::idx_t    mem_raddr;

    // per-request registers
    dsa_pkg::cmd_t    cmd_reg;
    dsa_pkg::count_t  count_reg;
    dsa_pkg::slot_t   slot_reg;
    dsa_pkg::status_t st_reg;
    dsa_pkg::status_t st_next;
    logic             has_slot_reg;
    logic             has_slot_next;
    logic             pop_reg;
    logic             pop_next;
    dsa_pkg::idx_t    idx_reg;
    dsa_pkg::idx_t    idx_sel;
    dsa_pkg::idx_t    fin_idx_reg;
    dsa_pkg::prod_t   prod_reg;

    // output register
    dsa_pkg::status_t status_reg;
    dsa_pkg::slot_t   first_slot_reg;
    dsa_pkg::addr_t   cpu_address_reg;
    dsa_pkg::addr_t   gpu_address_reg;
    dsa_pkg::live_t   live_count_reg;

    // decision terms
    dsa_pkg::sum_t    cap_eff;
    dsa_pkg::sum_t    bump_n;
    dsa_pkg::sum_t    bump_end;
    logic             bump_ok;
    dsa_pkg::cnt_t    fd_dec;
    dsa_pkg::cnt_t    live_now;

    // effective capacity is clamped to the table size
    assign cap_eff  = (dsa_pkg::sum_t'(capacity_reg) > dsa_pkg::sum_t'(dsa_pkg::MAX_SLOTS))
                      ? dsa_pkg::sum_t'(dsa_pkg::MAX_SLOTS) : dsa_pkg::sum_t'(capacity_reg);
    assign bump_n   = (cmd_reg == dsa_pkg::CMD_ALLOC_ONE) ? dsa_pkg::sum_t'(1)
                                                          : dsa_pkg::sum_t'(count_reg);
    assign bump_end = dsa_pkg::sum_t'(high_water_reg) + bump_n;
    assign bump_ok  = (bump_n != '0) && (bump_end <= cap_eff);
    assign fd_dec   = free_depth_reg - dsa_pkg::cnt_t'(1);

    always_comb
    begin
        high_water_next = high_water_reg;
        free_depth_next = free_depth_reg;
        st_next         = dsa_pkg::ST_OK;
        has_slot_next   = 1'b0;
        pop_next        = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = free_depth_reg[dsa_pkg::IDX_W-1:0];
        mem_raddr       = fd_dec[dsa_pkg::IDX_W-1:0];
        if (ctrl.decide)
        begin
            if (cmd_reg == dsa_pkg::CMD_ALLOC_ONE && free_depth_reg != '0)
            begin
                // reuse the most recently freed slot
                free_depth_next = fd_dec;
                mem_re          = 1'b1;
                pop_next        = 1'b1;
                has_slot_next   = 1'b1;
            end
            else if (cmd_reg == dsa_pkg::CMD_ALLOC_ONE || cmd_reg == dsa_pkg::CMD_ALLOC_RANGE)
            begin
                if (bump_ok)
                begin
                    high_water_next = bump_end[dsa_pkg::CNT_W-1:0];
                    has_slot_next   = 1'b1;
                end
                else
                begin
                    st_next = dsa_pkg::ST_NOSPACE;
                end
            end
            else if (cmd_reg == dsa_pkg::CMD_FREE)
            begin
                if (dsa_pkg::sum_t'(slot_reg) >= dsa_pkg::sum_t'(high_water_reg)
                    || free_depth_reg >= dsa_pkg::cnt_t'(dsa_pkg::MAX_SLOTS))
                begin
                    st_next = dsa_pkg::ST_BADFREE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    free_depth_next = free_depth_reg + dsa_pkg::cnt_t'(1);
                end
            end
        end
    end

    assign idx_sel  = pop_reg ? rd_data_reg : idx_reg;
    assign live_now = (free_depth_reg > high_water_reg) ? '0 : high_water_reg - free_depth_reg;

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= dsa_pkg::CAPACITY_RST;
            stride_reg     <= dsa_pkg::STRIDE_RST;
            cpu_base_reg   <= '0;
            gpu_base_reg   <= '0;
            shader_vis_reg <= 1'b0;
            high_water_reg <= '0;
            free_depth_reg <= '0;
        end
        else
        begin
            high_water_reg <= high_water_next;
            free_depth_reg <= free_depth_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dsa_pkg::REG_CAPACITY:   capacity_reg   <= cfg_data[dsa_pkg::CAP_W-1:0];
                    dsa_pkg::REG_STRIDE:     stride_reg     <= cfg_data[dsa_pkg::STRIDE_W-1:0];
                    dsa_pkg::REG_CPU_BASE:   cpu_base_reg   <= cfg_data[dsa_pkg::ADDR_W-1:0];
                    dsa_pkg::REG_GPU_BASE:   gpu_base_reg   <= cfg_data[dsa_pkg::ADDR_W-1:0];
                    dsa_pkg::REG_SHADER_VIS: shader_vis_reg <= cfg_data[0];
                    default:                 ;
                endcase
            end
        end
    end

    // free stack, one port each way, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= dsa_pkg::idx_t'(slot_reg);
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= req_cmd;
            count_reg <= req_count;
            slot_reg  <= req_slot;
        end
        if (ctrl.decide)
        begin
            st_reg       <= st_next;
            has_slot_reg <= has_slot_next;
            pop_reg      <= pop_next;
            idx_reg      <= high_water_reg[dsa_pkg::IDX_W-1:0];
        end
        if (ctrl.mul)
        begin
            fin_idx_reg <= idx_sel;
            prod_reg    <= dsa_pkg::prod_t'(idx_sel) * dsa_pkg::prod_t'(stride_reg);
        end
        if (ctrl.load_out)
        begin
            status_reg      <= st_reg;
            first_slot_reg  <= has_slot_reg ? dsa_pkg::slot_t'(fin_idx_reg) : '0;
            cpu_address_reg <= has_slot_reg ? cpu_base_reg + dsa_pkg::addr_t'(prod_reg) : '0;
            gpu_address_reg <= (has_slot_reg && shader_vis_reg)
                               ? gpu_base_reg + dsa_pkg::addr_t'(prod_reg) : '0;
            live_count_reg  <= dsa_pkg::live_t'(live_now);
        end
    end

    assign status      = status_reg;
    assign first_slot  = first_slot_reg;
    assign cpu_address = cpu_address_reg;
    assign gpu_address = gpu_address_reg;
    assign live_count  = live_count_reg;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for descriptor_slot_allocator_unit. Requests go in on
// the request channel and an in-bench slot tracker predicts each response.
// The tracker keeps the high-water mark, the LIFO free stack and the config
// registers. Responses are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsa_pkg::*;

    // cmd 3 has no package name; the block answers it as a no-op
    localparam cmd_t CMD_UNUSED = 2'd3;

    // Cycles with no transfer on any channel before the run is declared hung
    localparam int HANG_LIMIT = 4000;
    // Cycles to keep watching after the last response
    localparam int TAIL_CYCLES = 16;

    typedef struct packed {
        status_t status;
        slot_t   first_slot;
        addr_t   cpu_address;
        addr_t   gpu_address;
        live_t   live_count;
    } alloc_rsp_t;

    // ------------------------------------------------------------------------
    // Slot tracker: mirrors allocator state, queues predicted responses,
    // checks what comes back.
    // ------------------------------------------------------------------------
    class alloc_tracker;
        int         capacity;
        int         stride;
        addr_t      cpu_base;
        addr_t      gpu_base;
        bit         shader_vis;
        int         high_water;
        int         free_depth;
        slot_t      free_slots[MAX_SLOTS];
        alloc_rsp_t awaited[$];
        int         errors;

        function new();
            capacity   = int'(CAPACITY_RST);
            stride     = int'(STRIDE_RST);
            cpu_base   = '0;
            gpu_base   = '0;
            shader_vis = 1'b0;
            high_water = 0;
            free_depth = 0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, cfg_dat_t val);
            case (idx)
                REG_CAPACITY:   capacity   = int'(cap_t'(val));
                REG_STRIDE:     stride     = int'(stride_t'(val));
                REG_CPU_BASE:   cpu_base   = val;
                REG_GPU_BASE:   gpu_base   = val;
                REG_SHADER_VIS: shader_vis = val[0];
                default: ;
            endcase
        endfunction

        // Predict the response to one accepted request and update state
        function void take_request(cmd_t cmd, count_t count, slot_t slot);
            alloc_rsp_t r;
            int         cap_eff;
            int         idx;
            bit         granted;
            addr_t      offset;

            cap_eff  = (capacity > MAX_SLOTS) ? MAX_SLOTS : capacity;
            r.status = ST_OK;
            granted  = 1'b0;
            idx      = 0;
            case (cmd)
                CMD_ALLOC_ONE:
                begin
                    if (free_depth > 0)
                    begin
                        free_depth--;
                        idx     = int'(free_slots[free_depth]);
                        granted = 1'b1;
                    end
                    else if (high_water + 1 <= cap_eff)
                    begin
                        idx     = high_water;
                        high_water++;
                        granted = 1'b1;
                    end
                    else
                        r.status = ST_NOSPACE;
                end
                CMD_ALLOC_RANGE:
                begin
                    // zero count is refused like an overflow
                    if (count != 0 && high_water + int'(count) <= cap_eff)
                    begin
                        idx        = high_water;
                        high_water = high_water + int'(count);
                        granted    = 1'b1;
                    end
                    else
                        r.status = ST_NOSPACE;
                end
                CMD_FREE:
                begin
                    // double frees are not caught, only mark and full stack
                    if (int'(slot) >= high_water || free_depth >= MAX_SLOTS)
                        r.status = ST_BADFREE;
                    else
                    begin
                        free_slots[free_depth] = slot;
                        free_depth++;
                    end
                end
                default: ;
            endcase

            offset        = addr_t'(idx) * addr_t'(stride);
            r.first_slot  = granted ? slot_t'(idx) : '0;
            r.cpu_address = granted ? cpu_base + offset : '0;
            r.gpu_address = (granted && shader_vis) ? gpu_base + offset : '0;
            // live count floors at zero once frees outnumber the mark
            r.live_count  = (free_depth > high_water) ? '0 : live_t'(high_water - free_depth);
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
            end
        endfunction

        function void match_response(alloc_rsp_t got);
            alloc_rsp_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: response with none outstanding, actual %h", $realtime, got);
            end
            else
            begin
                want = awaited.pop_front();
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("first_slot", 64'(want.first_slot), 64'(got.first_slot));
                check_field("cpu_address", want.cpu_address, got.cpu_address);
                check_field("gpu_address", want.gpu_address, got.gpu_address);
                check_field("live_count", 64'(want.live_count), 64'(got.live_count));
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    dsa_req_if req();
    dsa_rsp_if rsp();
    dsa_cfg_if cfg();

    descriptor_slot_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    alloc_tracker tracker;

    // Sender and receiver gap modes; quiet means back-to-back transfers
    bit send_quiet;
    bit recv_quiet;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Response side: random ready gaps, check every transfer
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        int served;
        served = 0;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (served % 50 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            gap = recv_quiet ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp.valid && rsp.ready));
            served++;
        end
    end

    always @(posedge clk)
    begin
        alloc_rsp_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status      = rsp.status;
            got.first_slot  = rsp.first_slot;
            got.cpu_address = rsp.cpu_address;
            got.gpu_address = rsp.gpu_address;
            got.live_count  = rsp.live_count;
            tracker.match_response(got);
        end
    end

    // Hang detector: any transfer on any channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
                 || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= HANG_LIMIT)
        begin
            $display("descriptor_slot_allocator_unit: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Request and config drivers
    // ------------------------------------------------------------------------

    // One request transfer, preceded by a random sender gap
    task automatic send_request(cmd_t c, count_t n, slot_t s);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= c;
        req.count <= n;
        req.slot  <= s;
        do
            @(posedge clk);
        while (!(req.valid && req.ready));
        tracker.take_request(c, n, s);
    endtask

    // Stop sending and wait until every predicted response has come back
    task automatic drain();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    // Write all five registers back to back; block must be idle
    task automatic configure(int cap, int strd, addr_t cpu, addr_t gpu, bit vis);
        cfg_idx_t regs [5];
        cfg_dat_t vals [5];
        cfg_dat_t junk;
        regs = '{REG_CAPACITY, REG_STRIDE, REG_CPU_BASE, REG_GPU_BASE, REG_SHADER_VIS};
        // narrow registers get random upper bits now and then; they must be dropped
        junk = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
        vals[0] = {junk[63:CAP_W], cap_t'(cap)};
        vals[1] = {junk[63:STRIDE_W], stride_t'(strd)};
        vals[2] = cpu;
        vals[3] = gpu;
        vals[4] = {junk[63:1], vis};
        for (int k = 0; k < 5; k++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= regs[k];
            cfg.data  <= vals[k];
            do
                @(posedge clk);
            while (!(cfg.valid && cfg.ready));
            tracker.write_reg(regs[k], vals[k]);
        end
        cfg.valid <= 1'b0;
    endtask

    function automatic addr_t rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Mixed traffic: mostly allocs and frees of live slots, some strays
    task automatic random_phase(int items, int big_pct);
        int     pick;
        int     hw;
        cmd_t   c;
        count_t n;
        slot_t  s;
        for (int i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            // unused fields carry random bits
            n    = count_t'($urandom);
            s    = slot_t'($urandom);
            hw   = tracker.high_water;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                c = CMD_ALLOC_ONE;
            else if (pick < 55)
            begin
                c = CMD_ALLOC_RANGE;
                if ($urandom_range(0, 99) < big_pct)
                    n = count_t'($urandom_range(0, 2047));
                else
                    n = count_t'($urandom_range(1, 8));
            end
            else if (pick < 93)
            begin
                c    = CMD_FREE;
                pick = $urandom_range(0, 9);
                if (pick < 7 && hw > 0)
                    s = slot_t'($urandom_range(0, hw - 1));
                else if (pick == 7)
                    s = slot_t'((hw > 1023) ? 1023 : hw);   // right at the mark
            end
            else
                c = CMD_UNUSED;
            send_request(c, n, s);
            // now and then let the pipe run dry
            if ($urandom_range(0, 63) == 0)
                drain();
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        tracker    = new();
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.cmd   <= CMD_ALLOC_ONE;
        req.count <= '0;
        req.slot  <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_CAPACITY;
        cfg.data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero capacity: every bump fails, nothing to free yet
        configure(0, 2047, '1, '0, 1'b1);
        send_request(CMD_ALLOC_ONE, 11'd2047, 10'd1023);
        send_request(CMD_ALLOC_RANGE, 11'd0, 10'd0);
        send_request(CMD_ALLOC_RANGE, 11'd1, 10'd0);
        send_request(CMD_FREE, 11'd0, 10'd0);
        send_request(CMD_UNUSED, 11'd2047, 10'd1023);
        drain();

        // Capacity above the table size is clipped; widest stride, bases all ones
        configure(2047, 2047, '1, '1, 1'b1);
        send_request(CMD_ALLOC_RANGE, 11'd2047, 10'd0);
        send_request(CMD_ALLOC_RANGE, 11'd1025, 10'd0);
        send_request(CMD_ALLOC_ONE, 11'd0, 10'd0);
        send_request(CMD_ALLOC_RANGE, 11'd3, 10'd1023);
        send_request(CMD_FREE, 11'd0, 10'd3);
        send_request(CMD_FREE, 11'd0, 10'd0);
        send_request(CMD_FREE, 11'd0, 10'd4);      // at the mark
        send_request(CMD_FREE, 11'd2047, 10'd1023);
        send_request(CMD_ALLOC_ONE, 11'd0, 10'd0); // pops 0 (LIFO)
        send_request(CMD_ALLOC_ONE, 11'd0, 10'd0); // pops 3
        send_request(CMD_ALLOC_ONE, 11'd0, 10'd0); // stack empty, bumps
        // same slot freed again and again until frees outnumber the mark
        repeat (6) send_request(CMD_FREE, 11'd0, 10'd0);
        send_request(CMD_ALLOC_ONE, 11'd0, 10'd0);
        send_request(CMD_UNUSED, 11'd0, 10'd0);
        drain();

        // Capacity and stride of one, host side only
        configure(1, 1, rand_addr(), rand_addr(), 1'b0);
        random_phase(40, 0);
        configure(64, $urandom_range(1, 1024), rand_addr(), rand_addr(), 1'b1);
        random_phase(80, 5);
        configure(300, 0, rand_addr(), rand_addr(), 1'b1);
        random_phase(80, 5);
        configure(1024, 1024, '1, rand_addr(), 1'b0);
        random_phase(100, 10);
        // Capacity under the mark: popped slots beyond it still come out
        configure(8, $urandom_range(1, 2047), rand_addr(), rand_addr(), 1'b1);
        random_phase(60, 5);

        // Fill the free stack to the brim, then a few frees that bounce off it
        configure(2047, 2047, rand_addr(), rand_addr(), 1'b1);
        send_quiet = 1'b0;
        if (tracker.high_water == 0)
            send_request(CMD_ALLOC_ONE, '0, '0);
        while (tracker.free_depth < MAX_SLOTS)
        begin
            if ($urandom_range(0, 15) == 0)
                send_request(CMD_ALLOC_ONE, count_t'($urandom), slot_t'($urandom));
            else
                send_request(CMD_FREE, count_t'($urandom),
                             slot_t'($urandom_range(0, tracker.high_water - 1)));
            if (tracker.free_depth % 200 == 0)
                send_quiet = ($urandom_range(0, 2) == 0);
        end
        repeat (6) send_request(CMD_FREE, '0, '0);
        drain();

        configure($urandom_range(0, 2047), $urandom_range(0, 2047), rand_addr(), rand_addr(),
                  1'($urandom_range(0, 1)));
        random_phase(80, 10);

        // All responses in; keep watching for stray ones
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("descriptor_slot_allocator_unit: match");
        else
            $display("descriptor_slot_allocator_unit: mismatch");
        $finish;
    end

endmodule
